### hdl/cmi_pkg.sv
// Package for the colormap interpolator: words, codes and shared constants.
package cmi_pkg;

	localparam int MAX_COLORS_DEF = 16;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int CNT_W          = 5;
	localparam int CFG_IDX_W      = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RANGE_MIN = 3'd0,
		CFG_RANGE_MAX = 3'd1,
		CFG_COUNT     = 3'd2,
		CFG_CLIP      = 3'd3,
		CFG_SATURATE  = 3'd4
	} cfg_idx_t;

	typedef enum logic {
		REQ_MAP   = 1'b0,
		REQ_WRITE = 1'b1
	} req_t;

	typedef enum logic [1:0] {
		REGION_INTERP = 2'd0,
		REGION_CLIP   = 2'd1,
		REGION_SAT    = 2'd2,
		REGION_EMPTY  = 2'd3
	} region_t;

	typedef struct packed {
		req_t               req_type;
		logic signed [31:0] sample_value;
		logic [3:0]         entry_index;
		logic [31:0]        entry_color;
	} in_word_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		region_t    region;
	} out_word_t;

	// Control carried alongside the datapath; color holds the write data for
	// table writes and the final color once a result is fixed early.
	typedef struct packed {
		logic        wr;
		logic        fin;
		region_t     region;
		logic [31:0] color;
		logic [3:0]  eidx;
	} ctl_t;

endpackage

### hdl/cmi_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cmi_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### hdl/cmi_div.sv
// Pipelined restoring divider producing the normalized fraction, one bit per stage.
module cmi_div import cmi_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 in_vld,
	input  ctl_t                 in_ctl,
	input  logic [31:0]          in_rem,
	input  logic [31:0]          in_dv,
	output logic                 out_vld,
	output ctl_t                 out_ctl,
	output logic [FRAC_BITS-1:0] out_q
);

	logic                 vld_s [FRAC_BITS];
	ctl_t                 ctl_s [FRAC_BITS];
	logic [31:0]          rem_s [FRAC_BITS];
	logic [31:0]          dv_s  [FRAC_BITS];
	logic [FRAC_BITS-1:0] q_s   [FRAC_BITS];

	for (genvar i = 0; i < FRAC_BITS; i++) begin : g_stage
		logic                 pv;
		ctl_t                 pc;
		logic [31:0]          pr;
		logic [31:0]          pd;
		logic [FRAC_BITS-1:0] pq;
		logic [32:0]          r2;
		logic                 ge;

		if (i == 0) begin : g_first
			assign pv = in_vld;
			assign pc = in_ctl;
			assign pr = in_rem;
			assign pd = in_dv;
			assign pq = '0;
		end else begin : g_next
			assign pv = vld_s[i-1];
			assign pc = ctl_s[i-1];
			assign pr = rem_s[i-1];
			assign pd = dv_s[i-1];
			assign pq = q_s[i-1];
		end

		assign r2 = {pr, 1'b0};
		assign ge = r2 >= {1'b0, pd};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (adv) begin
				vld_s[i] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				ctl_s[i] <= pc;
				dv_s[i]  <= pd;
				rem_s[i] <= ge ? 32'(r2 - {1'b0, pd}) : r2[31:0];
				q_s[i]   <= {pq[FRAC_BITS-2:0], ge};
			end
		end
	end

	assign out_vld = vld_s[FRAC_BITS-1];
	assign out_ctl = ctl_s[FRAC_BITS-1];
	assign out_q   = q_s[FRAC_BITS-1];

endmodule

### hdl/cmi_blend.sv
// Per-channel linear blend of two packed RGBA table entries.
module cmi_blend #(
	parameter int FRAC_BITS = 16
) (
	input  logic [31:0]          c1,
	input  logic [31:0]          c2,
	input  logic [FRAC_BITS-1:0] t,
	output logic [31:0]          color
);

	for (genvar ch = 0; ch < 4; ch++) begin : g_ch
		logic signed [8:0]           diff;
		logic signed [FRAC_BITS+9:0] prod;
		logic signed [FRAC_BITS+9:0] step;

		assign diff = $signed({1'b0, c2[ch*8 +: 8]}) - $signed({1'b0, c1[ch*8 +: 8]});
		assign prod = diff * $signed({1'b0, t});
		assign step = prod >>> FRAC_BITS;
		assign color[ch*8 +: 8] = c1[ch*8 +: 8] + step[7:0];
	end

endmodule

### hdl/colormap_interpolate.sv
// Top level of the piecewise linear colormap interpolator.
//
//  channel  signals                              word
//  in       in_valid, in_stall, in_data          in_word_t: map or table write
//  out      out_valid, out_stall, out_data       out_word_t: RGBA and region
//  cfg      cfg_valid, cfg_ready, cfg_index/data register write
//
// One word per cycle in while out_stall does not hold the pipeline; a map result
// passes s1, s2, the one-bit-per-stage divider, s3, the table read and the output register.
// Table writes travel the same pipeline and give no result.
// Reset clears the valids and loads the config defaults; the table holds garbage until written.
// A stalled output freezes the whole pipeline and raises in_stall.
module colormap_interpolate import cmi_pkg::*; #(
	parameter int MAX_COLORS = MAX_COLORS_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_word_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_word_t            out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	localparam int IW = $clog2(MAX_COLORS);

	logic signed [31:0] range_min_q, range_max_q;
	logic [CNT_W-1:0]   color_count_q;
	logic [31:0]        clip_color_q, sat_color_q;
	logic [CNT_W-1:0]   cnt_eff;
	logic               adv;

	assign cfg_ready = 1'b1;
	assign adv       = !out_valid || !out_stall;
	assign in_stall  = !adv;
	assign cnt_eff   = (32'(color_count_q) > 32'(MAX_COLORS)) ? CNT_W'(MAX_COLORS)
	                                                          : color_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_min_q   <= 32'sd0;
			range_max_q   <= 32'sd65536;
			color_count_q <= '0;
			clip_color_q  <= '0;
			sat_color_q   <= '1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_RANGE_MIN: range_min_q   <= cfg_data;
				CFG_RANGE_MAX: range_max_q   <= cfg_data;
				CFG_COUNT:     color_count_q <= cfg_data[CNT_W-1:0];
				CFG_CLIP:      clip_color_q  <= cfg_data;
				CFG_SATURATE:  sat_color_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// s1: offsets from range_min
	logic               vld_s1;
	ctl_t               ctl_s1;
	logic signed [32:0] n_s1, d_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s1.wr     <= (in_data.req_type == REQ_WRITE);
			ctl_s1.fin    <= 1'b0;
			ctl_s1.region <= REGION_INTERP;
			ctl_s1.color  <= in_data.entry_color;
			ctl_s1.eidx   <= in_data.entry_index;
			n_s1 <= 33'(in_data.sample_value) - 33'(range_min_q);
			d_s1 <= 33'(range_max_q) - 33'(range_min_q);
		end
	end

	// s2: range classification
	ctl_t        cls_ctl;
	logic        vld_s2;
	ctl_t        ctl_s2;
	logic [31:0] rem_s2, dv_s2;

	always_comb begin
		cls_ctl = ctl_s1;
		if (!ctl_s1.wr) begin
			if (cnt_eff == '0) begin
				cls_ctl.fin    = 1'b1;
				cls_ctl.region = REGION_EMPTY;
				cls_ctl.color  = '0;
			end else if (n_s1 <= 0) begin
				cls_ctl.fin    = 1'b1;
				cls_ctl.region = REGION_CLIP;
				cls_ctl.color  = clip_color_q;
			end else if (d_s1 <= 0 || n_s1 >= d_s1) begin
				cls_ctl.fin    = 1'b1;
				cls_ctl.region = REGION_SAT;
				cls_ctl.color  = sat_color_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s2 <= cls_ctl;
			rem_s2 <= n_s1[31:0];
			dv_s2  <= d_s1[31:0];
		end
	end

	logic                 div_vld;
	ctl_t                 div_ctl;
	logic [FRAC_BITS-1:0] div_u;

	cmi_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_vld  (vld_s2),
		.in_ctl  (ctl_s2),
		.in_rem  (rem_s2),
		.in_dv   (dv_s2),
		.out_vld (div_vld),
		.out_ctl (div_ctl),
		.out_q   (div_u)
	);

	// s3: segment index and weight
	logic [FRAC_BITS+CNT_W-1:0] p;
	logic [CNT_W:0]             seg, seg_sel, seg_nxt;
	ctl_t                       idx_ctl;
	logic [FRAC_BITS-1:0]       t_sel;
	logic                       vld_s3;
	ctl_t                       ctl_s3;
	logic [IW-1:0]              addr_a_s3, addr_b_s3;
	logic [FRAC_BITS-1:0]       t_s3;

	assign p   = (FRAC_BITS+CNT_W)'(div_u) * (FRAC_BITS+CNT_W)'(cnt_eff - 1'b1);
	assign seg = {1'b0, p[FRAC_BITS+CNT_W-1:FRAC_BITS]};

	always_comb begin
		idx_ctl = div_ctl;
		seg_sel = seg;
		t_sel   = p[FRAC_BITS-1:0];
		if (!div_ctl.wr && !div_ctl.fin && div_u == '0) begin
			idx_ctl.fin    = 1'b1;
			idx_ctl.region = REGION_CLIP;
			idx_ctl.color  = clip_color_q;
		end
		if (cnt_eff == CNT_W'(1)) begin
			seg_sel = '0;
			t_sel   = '0;
		end else if (seg + 1'b1 >= {1'b0, cnt_eff}) begin
			seg_sel = {1'b0, cnt_eff} - 2'd2;
		end
		// single entry: both reads stay on entry 0
		seg_nxt = (cnt_eff == CNT_W'(1)) ? '0 : seg_sel + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= div_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s3    <= idx_ctl;
			t_s3      <= t_sel;
			addr_a_s3 <= IW'(seg_sel);
			addr_b_s3 <= IW'(seg_nxt);
		end
	end

	// table: two copies so both neighbors are read at once
	logic          tbl_we;
	logic [IW-1:0] tbl_waddr;
	logic [31:0]   c1_s4, c2_s4;

	assign tbl_we    = adv && vld_s3 && ctl_s3.wr && (32'(ctl_s3.eidx) < 32'(MAX_COLORS));
	assign tbl_waddr = IW'(ctl_s3.eidx);

	cmi_ram #(.WIDTH(32), .DEPTH(MAX_COLORS)) u_ram_a (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (ctl_s3.color),
		.re    (adv),
		.raddr (addr_a_s3),
		.rdata (c1_s4)
	);

	cmi_ram #(.WIDTH(32), .DEPTH(MAX_COLORS)) u_ram_b (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (ctl_s3.color),
		.re    (adv),
		.raddr (addr_b_s3),
		.rdata (c2_s4)
	);

	// s4: blend and output word
	logic                 vld_s4;
	ctl_t                 ctl_s4;
	logic [FRAC_BITS-1:0] t_s4;
	logic [31:0]          mix;
	logic [31:0]          res_color;
	logic                 out_valid_q;
	out_word_t            out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s4 <= ctl_s3;
			t_s4   <= t_s3;
		end
	end

	cmi_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
		.c1    (c1_s4),
		.c2    (c2_s4),
		.t     (t_s4),
		.color (mix)
	);

	assign res_color = ctl_s4.fin ? ctl_s4.color : mix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= vld_s4 && !ctl_s4.wr;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q.red    <= res_color[31:24];
			out_data_q.green  <= res_color[23:16];
			out_data_q.blue   <= res_color[15:8];
			out_data_q.alpha  <= res_color[7:0];
			out_data_q.region <= ctl_s4.fin ? ctl_s4.region : REGION_INTERP;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

### hdl/cmi_checker.sv
// Port-level checker for the colormap interpolator, bound to the top level.
module cmi_checker import cmi_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input logic      out_valid,
	input logic      out_stall,
	input out_word_t out_data,
	input logic      cfg_ready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled output word changed");

	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a blocked output");

	a_empty_black: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.region == REGION_EMPTY |->
			out_data.red == 8'd0 && out_data.green == 8'd0 &&
			out_data.blue == 8'd0 && out_data.alpha == 8'd0)
		else $error("empty table result not zero");

	a_cfg_open: assert property (@(posedge clk) disable iff (!arst_n)
		!in_valid && !out_valid |-> cfg_ready)
		else $error("config port closed while idle");

endmodule

bind colormap_interpolate cmi_checker u_cmi_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data),
	.cfg_ready (cfg_ready)
);
